FILE: hw/rtl/sound_level_window_detector_macros.svh
// assertion macros shared by the sound level window detector rtl
// needs a clk and an active-low rst_n in the scope where a macro is used
`ifndef SOUND_LEVEL_WINDOW_DETECTOR_MACROS_SVH
`define SOUND_LEVEL_WINDOW_DETECTOR_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SLWD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (1'b1) |-> (cond)) \
        else $error(msg);

// consequence that must hold in the cycle after the trigger
`define SLWD_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/slwd_pkg.sv
// constants and register codes for the sound level window detector
// no dependencies
package slwd_pkg;

    // configuration register indexes
    localparam logic CFG_AMBIENT = 1'b0;
    localparam logic CFG_NOISE   = 1'b1;

    // fixed field widths
    localparam int AMBIENT_W   = 12;
    localparam int THRESH_W    = 9;
    localparam int LEVEL_W     = 7;
    localparam int SOUND_W     = 8;
    localparam int RAW_W       = 10;
    localparam int OUT_TDATA_W = 24;

    // level mapping constants
    localparam int LEVEL_FLOOR  = 100;
    localparam int LEVEL_CEIL   = 100;
    localparam int SMOOTH_SPAN  = 30;
    localparam int LOW_CUT      = 12;
    localparam int FINAL_BASE   = 15;

    // reciprocals: floor(n*M >> K) == floor(n/d) over the ranges used
    localparam logic [9:0]  RECIP3     = 10'd683;   // d = 3,  k = 11, n < 2048
    localparam int          RECIP3_SH  = 11;
    localparam logic [11:0] RECIP17    = 12'd3856;  // d = 17, k = 16, n < 2048
    localparam int          RECIP17_SH = 16;

endpackage

FILE: hw/rtl/sound_level_window_detector.sv
// sound level window detector top level: windowed deviation sum and peak, level finishing
// depends on slwd_pkg and sound_level_window_detector_macros.svh
//
// channel | dir | handshake          | beat contents
// --------+-----+--------------------+-----------------------------------------------
// s_axis  | in  | s_tvalid/s_tready  | one converter sample
// m_axis  | out | m_tvalid/m_tready  | one window result (sound level, raw level)
// cfg     | in  | cfg_we             | register write, cfg_addr selects the register
//
// one sample is taken every cycle while the output is not stalled; the accumulator folds it in
// from the input register, and a window result then reaches m_tvalid through the window total
// registers and the eight-register finishing chain (mean, blend, mapping, smoothing, final remap)
// the whole chain moves together: s_tready = !m_tvalid || m_tready, so a stalled result
// holds every stage; the output register decouples the two sides otherwise
// reset clears the window accumulators, the previous window level and both config registers
`include "sound_level_window_detector_macros.svh"

module sound_level_window_detector #(
    parameter int WINDOW_SIZE = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // sample stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [SAMPLE_BITS-1:0] sample
    // window result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [slwd_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [7:0] sound_level, [17:8] raw_level
    // configuration writes
    input  logic                                   cfg_we,
    input  logic                                   cfg_addr,
    input  logic [slwd_pkg::AMBIENT_W-1:0]         cfg_wdata
);

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = $clog2(WINDOW_SIZE);
    localparam int SUMW = SB + CW;          // window sum never reaches 2**SUMW
    localparam int NB   = SB + 3;           // 4*peak + mean
    localparam int K5   = NB + 3;
    localparam int K9   = SB + 4;
    localparam int RW   = SB + 2;           // signed raw level, at least 10 bits

    localparam logic [SUMW-1:0] MEAN_M = SUMW'((64'd1 << SUMW) / 64'(WINDOW_SIZE));
    localparam logic [SUMW-1:0] WIN_C  = SUMW'(WINDOW_SIZE);
    localparam logic [CW-1:0]   LAST_C = CW'(WINDOW_SIZE - 1);
    localparam logic [K5-1:0]   M5     = K5'(((64'd1 << K5) + 64'd4) / 64'd5);
    localparam logic [K9-1:0]   M9     = K9'(((64'd1 << K9) + 64'd8) / 64'd9);

    // ---------------------------------------------------------------- control
    logic adv;                 // every stage moves on this
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------------------------------------------------------- config
    logic [slwd_pkg::AMBIENT_W-1:0] ambient_reg;
    logic [slwd_pkg::THRESH_W-1:0]  thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg <= '0;
            thresh_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                slwd_pkg::CFG_AMBIENT: ambient_reg <= cfg_wdata;
                slwd_pkg::CFG_NOISE:   thresh_reg  <= cfg_wdata[slwd_pkg::THRESH_W-1:0];
                default:               ambient_reg <= ambient_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- valid chain
    logic a_valid_reg, w_valid_reg, p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic p4_valid_reg, p5_valid_reg, p6_valid_reg, p7_valid_reg, out_valid_reg;

    // ---------------------------------------------------------------- input register
    logic [SB-1:0] a_sample_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid)
            a_sample_reg <= s_tdata[SB-1:0];
    end

    // ---------------------------------------------------------------- accumulator
    logic [CW-1:0]   count_reg;
    logic [SUMW-1:0] sum_reg;
    logic [SB-1:0]   peak_reg;
    logic [SB-1:0]   ambient_s;
    logic [SB-1:0]   dev;
    logic [SUMW-1:0] sum_next;
    logic [SB-1:0]   peak_next;
    logic            last_sample;

    assign ambient_s   = SB'(ambient_reg);
    assign dev         = (a_sample_reg >= ambient_s) ? a_sample_reg - ambient_s
                                                     : ambient_s - a_sample_reg;
    assign sum_next    = sum_reg + SUMW'(dev);
    assign peak_next   = (dev > peak_reg) ? dev : peak_reg;
    assign last_sample = (count_reg == LAST_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            peak_reg  <= '0;
        end
        else if (adv && a_valid_reg)
        begin
            if (last_sample)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                peak_reg  <= '0;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_next;
                peak_reg  <= peak_next;
            end
        end
    end

    // window totals
    logic [SUMW-1:0] w_sum_reg;
    logic [SB-1:0]   w_peak_reg;

    always_ff @(posedge clk)
    begin
        if (adv && a_valid_reg && last_sample)
        begin
            w_sum_reg  <= sum_next;
            w_peak_reg <= peak_next;
        end
    end

    // ---------------------------------------------------------------- finishing chain
    // mean by reciprocal: estimate is exact or one low, fixed in the third stage
    logic [2*SUMW-1:0] p1_prod_reg;
    logic [SUMW-1:0]   p1_sum_reg;
    logic [SB-1:0]     p1_peak_reg;

    logic [SUMW-1:0]   p2_q_reg, p2_qw_reg, p2_sum_reg;
    logic [SB-1:0]     p2_peak_reg;
    logic [SUMW-1:0]   q_est;

    logic [NB-1:0]     p3_num_reg;
    logic [SUMW-1:0]   rem;
    logic [SB-1:0]     mean;

    logic [NB+K5-1:0]  prod5;
    logic [SB-1:0]     p4_level_reg;

    logic signed [SB:0] lvl_off;
    logic              off_neg;
    logic [SB-1:0]     off_mag;
    logic [SB+K9-1:0]  prod9;
    logic [SB-1:0]     p5_q9_reg;
    logic              p5_neg_reg;

    logic signed [RW-1:0] raw;
    logic [slwd_pkg::LEVEL_W-1:0] clamped, gated;
    logic [slwd_pkg::LEVEL_W-1:0] p6_v_reg;
    logic [slwd_pkg::RAW_W-1:0]   p6_raw_reg;

    logic [slwd_pkg::LEVEL_W-1:0] prev_reg;
    logic [slwd_pkg::LEVEL_W:0]   diff, diff_abs;
    logic [8:0]                   blend3;
    logic [18:0]                  prod3;
    logic [slwd_pkg::LEVEL_W-1:0] prev_next;
    logic [slwd_pkg::LEVEL_W-1:0] p7_s_reg;
    logic [slwd_pkg::RAW_W-1:0]   p7_raw_reg;

    logic [10:0]                  span20;
    logic [26:0]                  prod17;
    logic [slwd_pkg::SOUND_W-1:0] sound_next;
    logic [slwd_pkg::SOUND_W-1:0] sound_reg;
    logic [slwd_pkg::RAW_W-1:0]   raw_out_reg;

    // stage 2 and 3 arithmetic
    assign q_est = p1_prod_reg[2*SUMW-1:SUMW];
    assign rem   = p2_sum_reg - p2_qw_reg;
    assign mean  = SB'(p2_q_reg + SUMW'(rem >= WIN_C));

    // blend divided by five
    assign prod5 = (NB + K5)'(p3_num_reg) * (NB + K5)'(M5);

    // (level - 100) / 9, toward zero
    assign lvl_off = $signed({1'b0, p4_level_reg}) - (SB + 1)'(slwd_pkg::LEVEL_FLOOR);
    assign off_neg = lvl_off[SB];
    assign off_mag = off_neg ? SB'(-lvl_off) : SB'(lvl_off);
    assign prod9   = (SB + K9)'(off_mag) * (SB + K9)'(M9);

    // sign restore, clamp to 0..100, noise gate
    assign raw = p5_neg_reg ? -$signed(RW'(p5_q9_reg)) : $signed(RW'(p5_q9_reg));

    always_comb
    begin
        priority if (p5_neg_reg)
            clamped = '0;
        else if (p5_q9_reg > SB'(slwd_pkg::LEVEL_CEIL))
            clamped = slwd_pkg::LEVEL_W'(slwd_pkg::LEVEL_CEIL);
        else
            clamped = p5_q9_reg[slwd_pkg::LEVEL_W-1:0];
        gated = (slwd_pkg::THRESH_W'(clamped) <= thresh_reg) ? '0 : clamped;
    end

    // smoothing against the previous window: (v + 2*prev) / 3 when close
    assign diff     = {1'b0, p6_v_reg} - {1'b0, prev_reg};
    assign diff_abs = diff[slwd_pkg::LEVEL_W] ? -diff : diff;
    assign blend3   = 9'(p6_v_reg) + {1'b0, prev_reg, 1'b0};
    assign prod3    = 19'(blend3) * 19'(slwd_pkg::RECIP3);
    assign prev_next = (diff_abs < (slwd_pkg::LEVEL_W + 1)'(slwd_pkg::SMOOTH_SPAN))
                     ? prod3[slwd_pkg::RECIP3_SH+slwd_pkg::LEVEL_W-1:slwd_pkg::RECIP3_SH]
                     : p6_v_reg;

    // final remap: (v - 15) * 20 / 17; just under the base the offset itself is the answer
    assign span20 = (11'(p7_s_reg) - 11'(slwd_pkg::FINAL_BASE)) * 11'd20;
    assign prod17 = 27'(span20) * 27'(slwd_pkg::RECIP17);

    always_comb
    begin
        priority if (p7_s_reg <= slwd_pkg::LEVEL_W'(slwd_pkg::LOW_CUT))
            sound_next = '0;
        else if (p7_s_reg < slwd_pkg::LEVEL_W'(slwd_pkg::FINAL_BASE))
            sound_next = slwd_pkg::SOUND_W'(p7_s_reg) - slwd_pkg::SOUND_W'(slwd_pkg::FINAL_BASE);
        else
            sound_next = {1'b0,
                prod17[slwd_pkg::RECIP17_SH+slwd_pkg::LEVEL_W-1:slwd_pkg::RECIP17_SH]};
    end

    // payload registers of the chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_prod_reg  <= (2 * SUMW)'(w_sum_reg) * (2 * SUMW)'(MEAN_M);
            p1_sum_reg   <= w_sum_reg;
            p1_peak_reg  <= w_peak_reg;

            p2_q_reg     <= q_est;
            p2_qw_reg    <= SUMW'(q_est * WIN_C);
            p2_sum_reg   <= p1_sum_reg;
            p2_peak_reg  <= p1_peak_reg;

            p3_num_reg   <= NB'({p2_peak_reg, 2'b00}) + NB'(mean);

            p4_level_reg <= prod5[K5+SB-1:K5];

            p5_q9_reg    <= prod9[K9+SB-1:K9];
            p5_neg_reg   <= off_neg;

            p6_v_reg     <= gated;
            p6_raw_reg   <= raw[slwd_pkg::RAW_W-1:0];

            p7_s_reg     <= prev_next;
            p7_raw_reg   <= p6_raw_reg;

            if (p7_valid_reg)
            begin
                sound_reg   <= sound_next;
                raw_out_reg <= p7_raw_reg;
            end
        end
    end

    // previous window level, kept across windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else if (adv && p6_valid_reg)
            prev_reg <= prev_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            p7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= s_tvalid;
            w_valid_reg   <= a_valid_reg && last_sample;
            p1_valid_reg  <= w_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            p6_valid_reg  <= p5_valid_reg;
            p7_valid_reg  <= p6_valid_reg;
            out_valid_reg <= p7_valid_reg;
        end
    end

    // ---------------------------------------------------------------- outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(slwd_pkg::OUT_TDATA_W - slwd_pkg::RAW_W - slwd_pkg::SOUND_W){1'b0}},
                       raw_out_reg, sound_reg};

    // ---------------------------------------------------------------- checks
    `SLWD_ASSERT_NEXT(a_window_wrap, adv && a_valid_reg && last_sample, count_reg == '0, "window count did not wrap")
    `SLWD_ASSERT_ALWAYS(a_prev_range, prev_reg <= slwd_pkg::LEVEL_W'(slwd_pkg::LEVEL_CEIL), "previous level above ceiling")
    `SLWD_ASSERT_ALWAYS(a_sound_range, !m_tvalid || ($signed(sound_reg) >= -8'sd2 && $signed(sound_reg) <= 8'sd100), "sound level out of range")
    `SLWD_ASSERT_NEXT(a_result_lands, adv && p7_valid_reg, m_tvalid, "finished window did not reach output")

endmodule

FILE: tb/sound_level_window_detector_tb.sv
// self-checking bench for the sound level window detector: directed and random sample windows
// checks every window result against a behavioral level predictor kept inside this file
// depends on slwd_pkg and the sound_level_window_detector rtl
`timescale 1ns / 1ps

module sound_level_window_detector_tb;

    localparam int WINDOW_LEN  = 64;
    localparam int SAMPLE_W    = 12;
    localparam int SETTLE_CYC  = 12;     // extra drain wait after the result queue empties
    localparam int STALL_CYC   = 600;    // long receiver hold-off for the fill test

    // flavor of a random window
    typedef enum int {WIN_SPREAD, WIN_STEADY, WIN_NOISE, WIN_QUIET} window_style_t;

    typedef struct packed {
        logic [7:0] sound;
        logic [9:0] raw;
    } window_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;   // [11:0] sample
    logic                           m_tvalid;
    logic                           m_tready;
    logic [slwd_pkg::OUT_TDATA_W-1:0] m_tdata; // [7:0] sound_level, [17:8] raw_level
    logic                           cfg_we;
    logic                           cfg_addr;
    logic [slwd_pkg::AMBIENT_W-1:0] cfg_wdata;

    // predictor state: configuration copy and window accumulators
    logic [11:0]    ambient_cfg;
    logic [8:0]     thresh_cfg;
    int             win_count;
    logic [17:0]    dev_sum;
    logic [11:0]    dev_peak;
    int             prev_level;

    window_result_t level_queue[$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             stall_request;

    sound_level_window_detector #(
        .WINDOW_SIZE(WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    // fold one accepted sample into the window; on the last sample push the window result
    task automatic predict_window_sample(input logic [11:0] smp);
        logic [11:0]    dev;
        int             mean;
        int             level;
        int             raw;
        int             v;
        int             diff;
        int             fin;
        window_result_t res;
        dev = (smp >= ambient_cfg) ? smp - ambient_cfg : ambient_cfg - smp;
        dev_sum = dev_sum + dev;
        if (dev > dev_peak)
            dev_peak = dev;
        win_count++;
        if (win_count < WINDOW_LEN)
            return;
        mean  = int'(dev_sum) / WINDOW_LEN;
        level = (int'(dev_peak) * 4 + mean) / 5;
        // 100..1000 onto 0..100, truncating toward zero
        raw   = (level - 100) * 100 / 900;
        v = raw;
        if (v < 0)
            v = 0;
        if (v > 100)
            v = 100;
        if (v <= int'(thresh_cfg))
            v = 0;
        // smooth only small steps against the previous window
        diff = (v > prev_level) ? v - prev_level : prev_level - v;
        if (diff < 30)
            v = (v + 2 * prev_level) / 3;
        prev_level = v;
        // 13 and 14 land slightly negative here
        fin = (v <= 12) ? 0 : (v - 15) * 100 / 85;
        res.sound = fin[7:0];
        res.raw   = raw[9:0];
        level_queue.push_back(res);
        win_count = 0;
        dev_sum   = '0;
        dev_peak  = '0;
    endtask

    // offer one sample beat, with random gaps before it, and wait for acceptance
    task automatic send_sample(input logic [11:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_window_sample(smp);
    endtask

    // stop sending and wait until every window result has come out
    task automatic settle_results();
        s_tvalid <= 1'b0;
        while (level_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // both registers, back to back; only while the block is idle
    task automatic set_config(input logic [11:0] amb, input logic [8:0] thr);
        cfg_we    <= 1'b1;
        cfg_addr  <= slwd_pkg::CFG_AMBIENT;
        cfg_wdata <= amb;
        @(posedge clk);
        cfg_addr  <= slwd_pkg::CFG_NOISE;
        cfg_wdata <= {3'b000, thr};
        @(posedge clk);
        cfg_we    <= 1'b0;
        ambient_cfg = amb;
        thresh_cfg  = thr;
    endtask

    function automatic logic [11:0] clip_sample(input int x);
        if (x < 0)
            return 12'd0;
        if (x > 4095)
            return 12'd4095;
        return x[11:0];
    endfunction

    // constant deviation over the rest of the window gives level = dev exactly
    task automatic send_dev_window(input int dev);
        do
            send_sample(clip_sample(int'(ambient_cfg) + dev));
        while (win_count != 0);
    endtask

    task automatic send_swing_window(input logic [11:0] lo, input logic [11:0] hi);
        do
            send_sample(win_count[0] ? hi : lo);
        while (win_count != 0);
    endtask

    // one spike at the window start, the rest sits on ambient: peak far above mean
    task automatic send_spike_window(input logic [11:0] spike);
        send_sample(spike);
        while (win_count != 0)
            send_sample(ambient_cfg);
    endtask

    // finish the current window with random content of one flavor
    task automatic random_window();
        window_style_t style;
        int            pick;
        int            amp;
        int            target;
        int            x;
        pick = $urandom_range(99);
        if (pick < 40)
            style = WIN_SPREAD;
        else if (pick < 70)
            style = WIN_STEADY;
        else if (pick < 85)
            style = WIN_NOISE;
        else
            style = WIN_QUIET;
        amp = $urandom_range(80, 1100);
        // steady windows aim near the previous level so smoothing sees both sides of 30
        target = prev_level + $urandom_range(70) - 35;
        if (target < -5)
            target = -5;
        if (target > 110)
            target = 110;
        do
        begin
            case (style)
                WIN_SPREAD: x = int'(ambient_cfg) + $urandom_range(2 * amp) - amp;
                WIN_STEADY:
                begin
                    x = 100 + 9 * target + $urandom_range(8);
                    x = $urandom_range(1) ? int'(ambient_cfg) + x : int'(ambient_cfg) - x;
                end
                WIN_NOISE:  x = $urandom_range(4095);
                default:
                begin
                    if ($urandom_range(31) == 0)
                        x = $urandom_range(4095);
                    else
                        x = int'(ambient_cfg) + $urandom_range(40) - 20;
                end
            endcase
            send_sample(clip_sample(x));
        end
        while (win_count != 0);
    endtask

    task automatic random_config();
        logic [11:0] amb;
        logic [8:0]  thr;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 15)
            amb = 12'd0;
        else if (pick < 30)
            amb = 12'd4095;
        else if (pick < 60)
            amb = 12'($urandom_range(1500, 2600));
        else
            amb = 12'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 60)
            thr = 9'($urandom_range(60));
        else if (pick < 85)
            thr = 9'($urandom_range(448));
        else if (pick < 93)
            thr = 9'd0;
        else
            thr = 9'd448;
        set_config(amb, thr);
    endtask

    // registers left at reset: ambient 0, threshold 0
    task automatic test_reset_config();
        send_dev_window(0);
        send_dev_window(4095);
        send_dev_window(0);
        settle_results();
    endtask

    // exact levels through the mapping, the smoothing edge and the negative final codes
    task automatic test_level_mapping();
        set_config(12'd2048, 9'd0);
        send_dev_window(100 + 9 * 43);      // jump up, no smoothing
        send_dev_window(100 + 9 * 13);      // step of exactly 30, final level -2
        send_dev_window(100 + 9 * 44);
        send_dev_window(100 + 9 * 14);      // final level -1
        send_dev_window(0);                 // quiet window, most negative raw, smoothed
        send_swing_window(12'd0, 12'd4095);
        send_spike_window(12'd4095);
        settle_results();
        set_config(12'd0, 9'd0);
        send_dev_window(4095);
        settle_results();
        set_config(12'd4095, 9'd0);
        send_swing_window(12'd0, 12'd4095);
        settle_results();
    endtask

    // threshold boundary, and thresholds at, just under and above the clamped ceiling
    task automatic test_noise_threshold();
        set_config(12'd2048, 9'd50);
        send_dev_window(100 + 9 * 50);      // at the threshold: forced to zero
        send_dev_window(100 + 9 * 51);      // just above: kept
        settle_results();
        set_config(12'd2048, 9'd448);
        send_dev_window(2047);
        settle_results();
        set_config(12'd2048, 9'd100);
        send_dev_window(2047);
        settle_results();
        set_config(12'd2048, 9'd99);
        send_dev_window(2047);
        settle_results();
    endtask

    task automatic test_random_windows(input int windows, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int w = 0; w < windows; w++)
        begin
            if (w % 5 == 0)
            begin
                settle_results();
                random_config();
            end
            // loose noise beats shift where the next window boundary falls
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 40)) send_sample(12'($urandom_range(4095)));
            random_window();
        end
        settle_results();
    endtask

    // receiver holds off long enough that the chain fills and input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        stall_request = STALL_CYC;
        repeat (3) random_window();
        settle_results();
    endtask

    // result receiver: random idling, or a long counted hold-off on request
    initial
    begin
        int stall_len;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                stall_len     = stall_request;
                stall_request = 0;
                m_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every result beat is compared with the oldest expected window result
    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (level_queue.size() == 0)
                report_mismatch($sformatf("unexpected result beat %h", m_tdata));
            else
            begin
                want = level_queue.pop_front();
                if (m_tdata[7:0] !== want.sound)
                    report_mismatch($sformatf("sound_level got %0d want %0d",
                        $signed(m_tdata[7:0]), $signed(want.sound)));
                if (m_tdata[17:8] !== want.raw)
                    report_mismatch($sformatf("raw_level got %0d want %0d",
                        $signed(m_tdata[17:8]), $signed(want.raw)));
            end
        end
    end

    initial
    begin
        #400000;
        $display("** sound_level_window_detector: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= slwd_pkg::CFG_AMBIENT;
        cfg_wdata <= '0;
        ambient_cfg    = '0;
        thresh_cfg     = '0;
        win_count      = 0;
        dev_sum        = '0;
        dev_peak       = '0;
        prev_level     = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        stall_request  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_level_mapping();
        test_noise_threshold();
        test_random_windows(3, 31, 77);
        test_random_windows(3, 77, 31);
        test_random_windows(3, 0, 0);
        test_backpressure();

        settle_results();
        if (level_queue.size() != 0)
            report_mismatch($sformatf("%0d window results never came", level_queue.size()));
        if (mismatch_count == 0)
            $display("** sound_level_window_detector: PASSED **");
        else
            $display("** sound_level_window_detector: FAILED **");
        $finish;
    end

endmodule
